FILE: rtl/pie_pkg.sv
// Shared types, constants and arithmetic helpers for the polynomial evaluation unit.
package pie_pkg;

   localparam int DATA_W      = 32;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int NUM_COEFS   = 8;
   localparam int MAX_DEGREE  = 7;
   localparam int COEF_IDX_W  = $clog2(NUM_COEFS);
   localparam int CSR_INDEX_W = 4;
   localparam int DEN_W       = COEF_IDX_W + 1;
   localparam int RECIP_W     = DATA_W + 1;
   localparam int RECIP_SH_W  = 6;
   localparam int RECIP_P_W   = DATA_W + RECIP_W;
   localparam int WIDE_W      = PROD_W + 1;

   localparam logic signed [WIDE_W-1:0] Q_MAX = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [WIDE_W-1:0] Q_MIN = -WIDE_W'(64'sh0000_0000_8000_0000);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

   // floor(n / (i+1)) = (n * RECIP_TABLE[i]) >> RECIP_SH_TABLE[i], exact for n < 2^32
   localparam logic [NUM_COEFS-1:0][RECIP_W-1:0] RECIP_TABLE = {
      33'h1_0000_0000,
      33'h1_2492_4925,
      33'h0_AAAA_AAAB,
      33'h0_CCCC_CCCD,
      33'h1_0000_0000,
      33'h0_AAAA_AAAB,
      33'h1_0000_0000,
      33'h1_0000_0000
   };
   localparam logic [NUM_COEFS-1:0][RECIP_SH_W-1:0] RECIP_SH_TABLE = {
      6'd35, 6'd35, 6'd34, 6'd34, 6'd34, 6'd33, 6'd33, 6'd32
   };

   typedef enum logic {
      KIND_EVAL     = 1'b0,
      KIND_INTEGRAL = 1'b1
   } kind_type;

   typedef struct packed {
      logic                     kind;
      logic signed [DATA_W-1:0] x_value;
      logic signed [DATA_W-1:0] x_lower;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     overflow;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic                     kind;
      logic signed [DATA_W-1:0] x_hi;
      logic signed [DATA_W-1:0] x_lo;
      logic signed [DATA_W-1:0] acc_hi;
      logic signed [DATA_W-1:0] acc_lo;
      logic                     ovf_hi;
      logic                     ovf_lo;
   } stage_type;

   typedef struct packed {
      logic                     valid;
      logic                     kind;
      logic signed [DATA_W-1:0] x_hi;
      logic signed [DATA_W-1:0] x_lo;
      logic signed [PROD_W-1:0] prod_hi;
      logic signed [PROD_W-1:0] prod_lo;
      logic                     ovf_hi;
      logic                     ovf_lo;
   } prod_type;

   typedef struct packed {
      logic                     ovf;
      logic signed [DATA_W-1:0] value;
   } sat_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [COEF_IDX_W-1:0] idx;
   } div_status_type;

   function automatic sat_type sat32(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if (v > Q_MAX) begin
         r.ovf   = 1'b1;
         r.value = Q_MAX[DATA_W-1:0];
      end else if (v < Q_MIN) begin
         r.ovf   = 1'b1;
         r.value = Q_MIN[DATA_W-1:0];
      end else begin
         r.ovf   = 1'b0;
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // round(prod / 2^16), ties up, then add coefficient and clip
   function automatic sat_type horner_step(input logic signed [PROD_W-1:0] prod,
                                           input logic signed [DATA_W-1:0] coef);
      logic signed [PROD_W-1:0] scaled;
      logic signed [WIDE_W-1:0] sum;
      scaled = (prod + ROUND_HALF) >>> 16;
      sum    = WIDE_W'(scaled) + WIDE_W'(coef);
      return sat32(sum);
   endfunction

endpackage

FILE: rtl/pie_div.sv
// Signed coefficient over (index+1) by reciprocal multiply, rounded half away from zero.
module pie_div
   import pie_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [COEF_IDX_W-1:0]    idx,
   input  logic signed [DATA_W-1:0] coef,
   output div_status_type           status,
   output logic signed [DATA_W-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_W-1:0]     num_ff, num_in;
   logic [DATA_W-1:0]     quo_ff, quo_in;
   logic                  neg_ff, neg_in;
   logic [COEF_IDX_W-1:0] idx_ff, idx_in;

   logic [DEN_W-1:0]      den_start;
   logic [DATA_W-1:0]     mag;
   logic [RECIP_P_W-1:0]  recip_prod;
   logic [RECIP_P_W-1:0]  quo_full;

   always_comb begin
      den_start  = DEN_W'(idx) + DEN_W'(1);
      mag        = coef[DATA_W-1] ? DATA_W'(-coef) : DATA_W'(coef);
      recip_prod = RECIP_P_W'(num_ff) * RECIP_P_W'(RECIP_TABLE[idx_ff]);
      quo_full   = recip_prod >> RECIP_SH_TABLE[idx_ff];
   end

   always_comb begin
      busy_in = 1'b0;
      done_in = 1'b0;
      num_in  = num_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      idx_in  = idx_ff;
      if (start) begin
         busy_in = 1'b1;
         num_in  = mag + DATA_W'(den_start >> 1);
         neg_in  = coef[DATA_W-1];
         idx_in  = idx;
      end else if (busy_ff) begin
         quo_in  = quo_full[DATA_W-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign status.busy = busy_ff || done_ff;
   assign status.done = done_ff;
   assign status.idx  = idx_ff;
   assign quotient    = neg_ff ? DATA_W'(-quo_ff) : quo_ff;

endmodule

FILE: rtl/pie_cell.sv
// One Horner cell: registered multiply, then round, add coefficient and clip, two lanes.
module pie_cell
   import pie_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  stage_type                stage_in,
   input  logic signed [DATA_W-1:0] poly_coef,
   input  logic signed [DATA_W-1:0] anti_coef,
   output stage_type                stage_out
);

   prod_type  mul_ff, mul_in;
   stage_type out_ff, out_in;
   sat_type   step_hi, step_lo;
   logic signed [DATA_W-1:0] coef;

   always_comb begin
      mul_in.valid   = stage_in.valid;
      mul_in.kind    = stage_in.kind;
      mul_in.x_hi    = stage_in.x_hi;
      mul_in.x_lo    = stage_in.x_lo;
      mul_in.prod_hi = PROD_W'(stage_in.acc_hi) * PROD_W'(stage_in.x_hi);
      mul_in.prod_lo = PROD_W'(stage_in.acc_lo) * PROD_W'(stage_in.x_lo);
      mul_in.ovf_hi  = stage_in.ovf_hi;
      mul_in.ovf_lo  = stage_in.ovf_lo;
   end

   always_comb begin
      coef          = (mul_ff.kind == KIND_INTEGRAL) ? anti_coef : poly_coef;
      step_hi       = horner_step(mul_ff.prod_hi, coef);
      step_lo       = horner_step(mul_ff.prod_lo, coef);
      out_in.valid  = mul_ff.valid;
      out_in.kind   = mul_ff.kind;
      out_in.x_hi   = mul_ff.x_hi;
      out_in.x_lo   = mul_ff.x_lo;
      out_in.acc_hi = step_hi.value;
      out_in.acc_lo = step_lo.value;
      out_in.ovf_hi = mul_ff.ovf_hi | step_hi.ovf;
      out_in.ovf_lo = mul_ff.ovf_lo | step_lo.ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         mul_ff <= mul_in;
         out_ff <= out_in;
      end
   end

   assign stage_out = out_ff;

endmodule

FILE: rtl/polynomial_eval_and_integral_unit.sv
// Top level: coefficient registers, antiderivative divider and pipelined Horner cell chain.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+------------------------------------
//  request | start, busy, req_data                  | word taken when start & !busy
//  result  | rsp_strobe, rsp_data                   | one-cycle strobe, no backpressure
//  config  | csr_valid, csr_ready, csr_index, csr_data | write when csr_valid & csr_ready
//
// One word per cycle while busy is low; the strobe comes through 8 cells of two registers
// each plus the output register, the first loaded at the accepting edge.
// A coefficient write holds busy high and csr_ready low through the reciprocal
// multiply, then the antiderivative coefficient update.
// Reset clears all coefficients. The result side cannot stall.
module polynomial_eval_and_integral_unit
   import pie_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic signed [DATA_W-1:0] csr_data
);

   logic signed [DATA_W-1:0] coef_ff [NUM_COEFS];
   logic signed [DATA_W-1:0] anti_ff [NUM_COEFS];
   logic signed [DATA_W-1:0] poly_use [NUM_COEFS];
   logic signed [DATA_W-1:0] anti_use [NUM_COEFS];

   stage_type stage_w [NUM_COEFS+1];

   div_status_type           div_status;
   logic signed [DATA_W-1:0] div_quotient;
   logic                     csr_write;

   logic     rsp_strobe_ff, rsp_strobe_in;
   rsp_type  rsp_ff, rsp_in;
   sat_type  diff;

   assign csr_ready = !div_status.busy;
   assign busy      = div_status.busy;
   assign csr_write = csr_valid && csr_ready && (csr_index < CSR_INDEX_W'(NUM_COEFS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
            anti_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            coef_ff[csr_index[COEF_IDX_W-1:0]] <= csr_data;
         end
         if (div_status.done) begin
            anti_ff[div_status.idx] <= div_quotient;
         end
      end
   end

   pie_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_write),
      .idx      (csr_index[COEF_IDX_W-1:0]),
      .coef     (csr_data),
      .status   (div_status),
      .quotient (div_quotient)
   );

   for (genvar i = 0; i < NUM_COEFS; i++) begin : g_use
      assign poly_use[i] = (i <= MAX_DEGREE) ? coef_ff[i] : '0;
      assign anti_use[i] = (i <= MAX_DEGREE) ? anti_ff[i] : '0;
   end

   always_comb begin
      stage_w[0].valid  = start && !busy;
      stage_w[0].kind   = req_data.kind;
      stage_w[0].x_hi   = req_data.x_value;
      stage_w[0].x_lo   = req_data.x_lower;
      stage_w[0].acc_hi = (req_data.kind == KIND_INTEGRAL) ? anti_use[NUM_COEFS-1] : '0;
      stage_w[0].acc_lo = (req_data.kind == KIND_INTEGRAL) ? anti_use[NUM_COEFS-1] : '0;
      stage_w[0].ovf_hi = 1'b0;
      stage_w[0].ovf_lo = 1'b0;
   end

   for (genvar j = 0; j < NUM_COEFS; j++) begin : g_cell
      logic signed [DATA_W-1:0] anti_coef;
      if (j == NUM_COEFS - 1) begin : g_last
         assign anti_coef = '0;
      end else begin : g_mid
         assign anti_coef = anti_use[NUM_COEFS-2-j];
      end
      pie_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage_w[j]),
         .poly_coef (poly_use[NUM_COEFS-1-j]),
         .anti_coef (anti_coef),
         .stage_out (stage_w[j+1])
      );
   end

   always_comb begin
      diff = sat32(WIDE_W'(stage_w[NUM_COEFS].acc_hi) - WIDE_W'(stage_w[NUM_COEFS].acc_lo));
      rsp_strobe_in = stage_w[NUM_COEFS].valid;
      if (stage_w[NUM_COEFS].kind == KIND_INTEGRAL) begin
         rsp_in.value    = diff.value;
         rsp_in.overflow = stage_w[NUM_COEFS].ovf_hi | stage_w[NUM_COEFS].ovf_lo | diff.ovf;
      end else begin
         rsp_in.value    = stage_w[NUM_COEFS].acc_hi;
         rsp_in.overflow = stage_w[NUM_COEFS].ovf_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: test/polynomial_eval_and_integral_unit_tb.sv
// Self-checking testbench for the polynomial evaluation and integral unit.
module polynomial_eval_and_integral_unit_tb;
   import pie_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] Q_ONE    = 32'h0001_0000;
   localparam int POINTS_PER_PHASE = 127;
   localparam int RANDOM_PHASES    = 12;
   localparam int QUIET_PHASES     = 2;
   localparam int TAIL_CYCLES      = 40;

   logic                     clock;
   logic                     reset;
   logic                     start = 1'b0;
   logic                     busy;
   req_type                  req_data = '0;
   logic                     rsp_strobe;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic signed [DATA_W-1:0] csr_data;

   req_type                  point_words[$];
   rsp_type                  poly_results_due[$];
   logic signed [DATA_W-1:0] coef_q [NUM_COEFS];
   logic                     word_taken = 1'b0;
   bit                       bursts_on = 1'b1;
   int                       idle_left = 0;
   int                       mismatch_count = 0;
   rsp_type                  due;

   polynomial_eval_and_integral_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint clip_q(input longint v, inout bit ovf);
      if (v > longint'(WORD_MAX)) begin
         ovf = 1'b1;
         return longint'(WORD_MAX);
      end
      if (v < -longint'(WORD_MAX) - 1) begin
         ovf = 1'b1;
         return -longint'(WORD_MAX) - 1;
      end
      return v;
   endfunction

   function automatic longint horner_q(input longint a [NUM_COEFS+1], input int top,
                                       input longint x, inout bit ovf);
      longint acc;
      longint scaled;
      acc = a[top];
      for (int i = top - 1; i >= 0; i--) begin
         scaled = (acc * x + 64'sd32768) >>> 16;
         acc = clip_q(scaled + a[i], ovf);
      end
      return acc;
   endfunction

   // nearest, ties away from zero
   function automatic longint anti_coef(input longint c, input longint d);
      longint mag;
      longint q;
      mag = (c < 0) ? -c : c;
      q = (mag + d / 2) / d;
      return (c < 0) ? -q : q;
   endfunction

   function automatic rsp_type poly_result(input req_type w);
      longint  poly [NUM_COEFS+1];
      longint  anti [NUM_COEFS+1];
      longint  f_hi;
      longint  f_lo;
      longint  r;
      bit      ovf;
      rsp_type o;
      ovf = 1'b0;
      for (int i = 0; i <= NUM_COEFS; i++) begin
         poly[i] = 0;
      end
      for (int i = 0; i < NUM_COEFS; i++) begin
         poly[i] = (i <= MAX_DEGREE) ? longint'(coef_q[i]) : 0;
      end
      if (w.kind == KIND_EVAL) begin
         r = horner_q(poly, NUM_COEFS - 1, longint'(w.x_value), ovf);
      end else begin
         anti[0] = 0;
         for (int i = 0; i < NUM_COEFS; i++) begin
            anti[i+1] = anti_coef(poly[i], longint'(i + 1));
         end
         f_hi = horner_q(anti, NUM_COEFS, longint'(w.x_value), ovf);
         f_lo = horner_q(anti, NUM_COEFS, longint'(w.x_lower), ovf);
         r = clip_q(f_hi - f_lo, ovf);
      end
      o.value    = r[DATA_W-1:0];
      o.overflow = ovf;
      return o;
   endfunction

   function automatic logic [DATA_W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return '1;
         default: return Q_ONE;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] small_q();
      return DATA_W'(int'($urandom_range(0, 2**18)) - 2**17);
   endfunction

   function automatic logic [DATA_W-1:0] rand_point();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1, 2: return small_q();
         3: return DATA_W'(int'($urandom_range(0, 2**22)) - 2**21);
         4: return DATA_W'(int'($urandom_range(0, 2**14)) - 2**13);
         default: return pick_extreme();
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_coef(input int mode);
      case (mode)
         0: return small_q();
         1: return $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: return pick_extreme();
               1: return small_q();
               2: return '0;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   task automatic push_point(input kind_type k, input logic [DATA_W-1:0] x,
                             input logic [DATA_W-1:0] lo);
      req_type w;
      w.kind    = k;
      w.x_value = x;
      w.x_lower = lo;
      point_words.push_back(w);
   endtask

   task automatic write_csr(input int idx, input logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_INDEX_W'(idx);
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // every coefficient plus one write to an unused index, which must be ignored
   task automatic load_coefs(input logic [DATA_W-1:0] vals [NUM_COEFS]);
      for (int i = 0; i < NUM_COEFS; i++) begin
         write_csr(i, vals[i]);
      end
      write_csr($urandom_range(NUM_COEFS, 2**CSR_INDEX_W - 1), $urandom);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (point_words.size() != 0 || start || poly_results_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         if (idle_left > 0) begin
            start     <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (point_words.size() != 0) begin
            req_data <= point_words.pop_front();
            start    <= 1'b1;
            if (bursts_on && $urandom_range(0, 9) == 0) begin
               idle_left <= $urandom_range(1, 16);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      if (reset) begin
         word_taken <= 1'b0;
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_q[i] <= '0;
         end
      end else begin
         word_taken <= start && !busy;
         if (rsp_strobe) begin
            if (poly_results_due.size() == 0) begin
               $display("%0t: unexpected word: value %h overflow %b",
                        $time, rsp_data.value, rsp_data.overflow);
               mismatch_count++;
            end else begin
               due = poly_results_due.pop_front();
               if (rsp_data.value !== due.value) begin
                  $display("%0t: value expected %h got %h", $time, due.value, rsp_data.value);
                  mismatch_count++;
               end
               if (rsp_data.overflow !== due.overflow) begin
                  $display("%0t: overflow expected %b got %b",
                           $time, due.overflow, rsp_data.overflow);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            poly_results_due.push_back(poly_result(req_data));
         end
         if (csr_valid && csr_ready && csr_index < NUM_COEFS) begin
            coef_q[csr_index[COEF_IDX_W-1:0]] <= csr_data;
         end
      end
   end

   initial begin
      #500_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [DATA_W-1:0] coef_set [NUM_COEFS];
      int                deg;
      int                mode;
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero polynomial
      push_point(KIND_EVAL, WORD_MAX, '0);
      push_point(KIND_EVAL, WORD_MIN, WORD_MAX);
      push_point(KIND_INTEGRAL, WORD_MAX, WORD_MIN);
      push_point(KIND_INTEGRAL, WORD_MIN, WORD_MAX);
      wait_idle();

      // all coefficients at the top, then the bottom of the range
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_set[i] = (s == 0) ? WORD_MAX : WORD_MIN;
         end
         load_coefs(coef_set);
         push_point(KIND_EVAL, Q_ONE, '0);
         push_point(KIND_EVAL, WORD_MAX, WORD_MIN);
         push_point(KIND_EVAL, '0, '1);
         push_point(KIND_EVAL, '1, '0);
         push_point(KIND_INTEGRAL, Q_ONE, '0);
         push_point(KIND_INTEGRAL, WORD_MIN, WORD_MAX);
         wait_idle();
      end

      // only the top term: antiderivative keeps degree 8
      for (int i = 0; i < NUM_COEFS; i++) begin
         coef_set[i] = '0;
      end
      coef_set[NUM_COEFS-1] = Q_ONE;
      load_coefs(coef_set);
      push_point(KIND_INTEGRAL, Q_ONE, -Q_ONE);
      push_point(KIND_INTEGRAL, Q_ONE << 1, '0);
      push_point(KIND_INTEGRAL, 32'sd1, -32'sd1);
      push_point(KIND_EVAL, 32'h0001_8000, '0);
      wait_idle();

      // odd tiny coefficients: a halfway case in the division at index 1
      for (int i = 0; i < NUM_COEFS; i++) begin
         coef_set[i] = DATA_W'((i % 2 == 0) ? 2 * i + 1 : -(2 * i + 1));
      end
      load_coefs(coef_set);
      push_point(KIND_INTEGRAL, Q_ONE, '0);
      push_point(KIND_INTEGRAL, '0, Q_ONE);
      push_point(KIND_EVAL, 32'h0000_8000, '0);
      push_point(KIND_EVAL, 32'hFFFF_8000, '1);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         bursts_on = (p < RANDOM_PHASES - QUIET_PHASES);
         mode = p % 4;
         deg  = $urandom_range(0, MAX_DEGREE);
         for (int i = 0; i < NUM_COEFS; i++) begin
            if (mode == 3) begin
               coef_set[i] = (i <= deg) ? rand_coef(0) : '0;
            end else begin
               coef_set[i] = rand_coef(mode);
            end
         end
         load_coefs(coef_set);
         for (int n = 0; n < POINTS_PER_PHASE; n++) begin
            push_point(kind_type'($urandom_range(0, 1)), rand_point(), rand_point());
         end
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
